### sv/bqc_pkg.sv
package bqc_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_SECTIONS_DEF   = 8;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Fixed sizes of the number formats and of the item fields.
    localparam int COEF_INT_BITS     = 4;
    localparam int COEFS_PER_SECTION = 6;
    localparam int STATE_BITS        = 32;
    localparam int SECIDX_BITS       = 3;
    localparam int SLOT_BITS         = 3;
    localparam int ACTION_BITS       = 2;
    localparam int CFG_BITS          = 4;
    localparam int STEP_BITS         = 3;

    // Actions carried in the input word's side band.
    localparam logic [ACTION_BITS-1:0] ACT_FILTER = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_LOAD   = 2'd2;

    // Coefficient slots within one section.
    localparam logic [SLOT_BITS-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_BITS-1:0] SLOT_A0 = 3'd3;
    localparam logic [SLOT_BITS-1:0] SLOT_A1 = 3'd4;
    localparam logic [SLOT_BITS-1:0] SLOT_A2 = 3'd5;

    // Product steps of one section, in the order the multiplier runs them.
    localparam logic [STEP_BITS-1:0] STEP_A0 = 3'd0;
    localparam logic [STEP_BITS-1:0] STEP_A1 = 3'd1;
    localparam logic [STEP_BITS-1:0] STEP_A2 = 3'd2;
    localparam logic [STEP_BITS-1:0] STEP_B0 = 3'd3;
    localparam logic [STEP_BITS-1:0] STEP_B1 = 3'd4;
    localparam logic [STEP_BITS-1:0] STEP_B2 = 3'd5;

    // Coefficient slot used by each product step.
    function automatic logic [SLOT_BITS-1:0] step_slot(input logic [STEP_BITS-1:0] step);
        logic [SLOT_BITS-1:0] slot;
        unique case (step)
            STEP_A0: slot = SLOT_A0;
            STEP_A1: slot = SLOT_A1;
            STEP_A2: slot = SLOT_A2;
            STEP_B0: slot = SLOT_B0;
            STEP_B1: slot = SLOT_B1;
            STEP_B2: slot = SLOT_B2;
            default: slot = SLOT_A0;
        endcase
        return slot;
    endfunction

endpackage

### sv/biquad_cascade_iir_filter_unit.sv
// Channel   | Dir | Handshake                     | Payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: sample, section_index, coef_index,
//           |     |                               |        coef_value; tuser: action
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: filtered; tuser: saturated
// cfg       | in  | i_cfg_we                      | i_cfg_wdata: sections_in_use
//
// A coefficient load leaves the block ready for the next word. A filter word occupies
// the block from its acceptance until its result enters the output register.
// The single multiplier sets that span: six products for each of the N sections in use.
// Reset is synchronous and active low; it zeroes the delays and marks every coefficient
// as zero. A finished result waits in the output register while the next word is taken;
// the block only stalls when a second result is ready before the first has been taken.
module biquad_cascade_iir_filter_unit
    import bqc_pkg::*;
#(
    parameter int MAX_SECTIONS   = MAX_SECTIONS_DEF,
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // From bit 0: sample, section_index, coef_index, coef_value, zero fill.
    input  logic [((SAMPLE_BITS + SECIDX_BITS + SLOT_BITS + COEF_FRAC_BITS
                    + COEF_INT_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // action
    input  logic [ACTION_BITS-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // From bit 0: filtered, zero fill.
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // saturated
    output logic                 m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_BITS-1:0]  i_cfg_wdata
);

    localparam int COEF_BITS   = COEF_FRAC_BITS + COEF_INT_BITS;
    localparam int CDEPTH      = MAX_SECTIONS * COEFS_PER_SECTION;
    localparam int CADDR_W     = $clog2(CDEPTH);
    localparam int SEC_W       = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_SECTIONS + 1);
    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PROD_W      = COEF_BITS + STATE_BITS;
    localparam int ACC_W       = PROD_W - COEF_FRAC_BITS + 2;

    localparam logic signed [ACC_W-1:0] ST_HI = ACC_W'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ST_LO = -ST_HI - ACC_W'(1);
    localparam logic signed [STATE_BITS-1:0] SMP_HI =
        STATE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [STATE_BITS-1:0] SMP_LO = -SMP_HI - STATE_BITS'(1);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    function automatic logic [CADDR_W-1:0] coef_addr(input logic [7:0] sec,
                                                     input logic [SLOT_BITS-1:0] slot);
        logic [11:0] full;
        full = 12'(sec) * 12'(COEFS_PER_SECTION) + 12'(slot);
        return full[CADDR_W-1:0];
    endfunction

    // Input word fields.
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [SECIDX_BITS-1:0]        in_sidx;
    logic [SLOT_BITS-1:0]          in_slot;
    logic [COEF_BITS-1:0]          in_coef;

    assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_sidx   = s_axis_tdata[SAMPLE_BITS +: SECIDX_BITS];
    assign in_slot   = s_axis_tdata[SAMPLE_BITS + SECIDX_BITS +: SLOT_BITS];
    assign in_coef   = s_axis_tdata[SAMPLE_BITS + SECIDX_BITS + SLOT_BITS +: COEF_BITS];

    logic [1:0]                    r_state;
    logic [CFG_BITS-1:0]           r_sections;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              r_sec;
    logic [STEP_BITS-1:0]          r_step;
    logic signed [STATE_BITS-1:0]  r_x;
    logic signed [STATE_BITS-1:0]  r_w;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [STATE_BITS-1:0]  r_d1 [MAX_SECTIONS];
    logic signed [STATE_BITS-1:0]  r_d2 [MAX_SECTIONS];
    logic [CDEPTH-1:0]             r_cvalid;
    logic                          r_rvalid;
    logic                          r_out_valid;
    logic [SAMPLE_BITS-1:0]        r_out_data;
    logic                          r_out_sat;

    logic                          s_acc;
    logic                          is_filter;
    logic                          load_ok;
    logic [CNT_W-1:0]              count_sel;
    logic                          more_secs;
    logic                          rd_en;
    logic [CADDR_W-1:0]            rd_addr;
    logic [CADDR_W-1:0]            wr_addr;
    logic [COEF_BITS-1:0]          ram_rdata;
    logic signed [COEF_BITS-1:0]   coef_q;
    logic signed [STATE_BITS-1:0]  mul_op;
    logic signed [PROD_W-1:0]      n_prod;
    logic signed [ACC_W-1:0]       shifted;
    logic signed [ACC_W-1:0]       n_acc;
    logic signed [STATE_BITS-1:0]  acc_sat;
    logic [SEC_W-1:0]              sec_idx;
    logic signed [STATE_BITS-1:0]  out_val;
    logic                          out_clip;
    logic                          out_load;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign is_filter     = (s_axis_tuser == ACT_FILTER) || (s_axis_tuser == ACT_CLEAR);
    assign load_ok       = (s_axis_tuser == ACT_LOAD) && (in_slot < SLOT_BITS'(COEFS_PER_SECTION))
                           && (32'(in_sidx) < 32'(MAX_SECTIONS));
    assign wr_addr       = coef_addr(8'(in_sidx), in_slot);
    assign sec_idx       = r_sec[SEC_W-1:0];

    // A count of zero runs one section; a count above the table runs all of them.
    always_comb begin
        priority if (r_sections == '0) begin
            count_sel = CNT_W'(1);
        end else if (32'(r_sections) > 32'(MAX_SECTIONS)) begin
            count_sel = CNT_W'(MAX_SECTIONS);
        end else begin
            count_sel = CNT_W'(r_sections);
        end
    end

    assign more_secs = ({1'b0, r_sec} + (CNT_W + 1)'(1)) < {1'b0, r_count};

    // Each coefficient is read ahead of its multiply, in IDLE or the prior product's ST_MUL.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (r_state == ST_IDLE) begin
            rd_en   = s_acc && is_filter;
            rd_addr = coef_addr(8'd0, step_slot(STEP_A0));
        end else if (r_state == ST_MUL) begin
            if (r_step != STEP_B2) begin
                rd_en   = 1'b1;
                rd_addr = coef_addr(8'(r_sec), step_slot(r_step + STEP_BITS'(1)));
            end else begin
                rd_en   = more_secs;
                rd_addr = coef_addr(8'(r_sec) + 8'd1, step_slot(STEP_A0));
            end
        end
    end

    bqc_ram #(
        .WIDTH(COEF_BITS),
        .DEPTH(CDEPTH)
    ) u_coef_ram (
        .i_clk  (i_clk),
        .i_we   (s_acc && load_ok),
        .i_waddr(wr_addr),
        .i_wdata(in_coef),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(ram_rdata)
    );

    // A slot never loaded since reset reads as zero.
    assign coef_q = r_rvalid ? ram_rdata : '0;

    always_comb begin
        unique case (r_step)
            STEP_A0:          mul_op = r_x;
            STEP_A1, STEP_B1: mul_op = r_d1[sec_idx];
            STEP_A2, STEP_B2: mul_op = r_d2[sec_idx];
            STEP_B0:          mul_op = r_w;
            default:          mul_op = r_x;
        endcase
    end

    assign n_prod  = coef_q * mul_op;
    assign shifted = ACC_W'(r_prod >>> COEF_FRAC_BITS);

    always_comb begin
        unique case (r_step)
            STEP_A0, STEP_B0: n_acc = shifted;
            STEP_A1, STEP_A2: n_acc = r_acc - shifted;
            STEP_B1, STEP_B2: n_acc = r_acc + shifted;
            default:          n_acc = shifted;
        endcase
    end

    always_comb begin
        priority if (n_acc > ST_HI) begin
            acc_sat = STATE_BITS'(ST_HI);
        end else if (n_acc < ST_LO) begin
            acc_sat = STATE_BITS'(ST_LO);
        end else begin
            acc_sat = STATE_BITS'(n_acc);
        end
    end

    always_comb begin
        out_clip = 1'b1;
        priority if (r_x > SMP_HI) begin
            out_val = SMP_HI;
        end else if (r_x < SMP_LO) begin
            out_val = SMP_LO;
        end else begin
            out_val  = r_x;
            out_clip = 1'b0;
        end
    end

    assign out_load = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sections  <= CFG_BITS'(1);
            r_count     <= CNT_W'(1);
            r_sec       <= '0;
            r_step      <= STEP_A0;
            r_cvalid    <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                r_d1[i] <= '0;
                r_d2[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_sections <= i_cfg_wdata;
            end
            if (rd_en) begin
                r_rvalid <= r_cvalid[rd_addr];
            end
            // A new result replaces one that is taken in the same cycle.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_acc && load_ok) begin
                        r_cvalid[wr_addr] <= 1'b1;
                    end
                    if (s_acc && is_filter) begin
                        r_count <= count_sel;
                        r_sec   <= '0;
                        r_step  <= STEP_A0;
                        r_state <= ST_MUL;
                        if (s_axis_tuser == ACT_CLEAR) begin
                            for (int i = 0; i < MAX_SECTIONS; i++) begin
                                r_d1[i] <= '0;
                                r_d2[i] <= '0;
                            end
                        end
                    end
                end
                ST_MUL: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_step == STEP_B2) begin
                        r_d2[sec_idx] <= r_d1[sec_idx];
                        r_d1[sec_idx] <= r_w;
                        if (more_secs) begin
                            r_sec   <= r_sec + CNT_W'(1);
                            r_step  <= STEP_A0;
                            r_state <= ST_MUL;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end else begin
                        r_step  <= r_step + STEP_BITS'(1);
                        r_state <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (s_acc && is_filter) begin
            r_x <= {{(STATE_BITS - SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};
        end
        if (r_state == ST_MUL) begin
            r_prod <= n_prod;
        end
        if (r_state == ST_ACC) begin
            r_acc <= n_acc;
            if (r_step == STEP_A2) begin
                r_w <= acc_sat;
            end
            if (r_step == STEP_B2) begin
                r_x <= acc_sat;
            end
        end
        if (out_load) begin
            r_out_data <= out_val[SAMPLE_BITS-1:0];
            r_out_sat  <= out_clip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);
    assign m_axis_tuser  = r_out_sat;

    // The step counter never runs past the last product of a section.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_B2)
        else $error("product step out of range");

    // While the multiplier works, the section index stays below the latched count.
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL || r_state == ST_ACC) |-> (r_sec < r_count))
        else $error("section index beyond sections in use");

    // An accepted filter word starts the first product of section zero.
    a_filter_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && is_filter) |=> (r_state == ST_MUL && r_step == STEP_A0 && r_sec == '0))
        else $error("filter word did not start the sequencer");

    // A new result only appears after the output stage of the sequencer.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_OUT))
        else $error("result raised outside the output stage");

endmodule

### sv/bqc_ram.sv
module bqc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the biquad cascade.
//
// Input words are queued by the stimulus process and handed to the block by a clocked
// driver. When a word is accepted, the driver runs it through a local fixed-point
// model of the cascade. Filter and clear words add one pending result each.
// A clocked monitor takes result words from the block and compares them, field by
// field, with the oldest pending result.
//
// The run has three parts. A short directed part covers field extremes, output
// saturation, ignored slots, the unused action, the clear request and an idle
// section. Random phases follow, each with its own section count. Some counts are
// zero or above the table size. Each phase loads stable coefficient sets for the
// active sections and then sends a mix of samples, clears, coefficient reloads,
// raw full-range loads and unused actions. In one phase the receiver holds off for
// a long stretch. The block then fills up and stalls its input.
module testbench;
    import bqc_pkg::*;

    localparam int SAMPLE_W = SAMPLE_BITS_DEF;
    localparam int COEF_W   = COEF_INT_BITS + COEF_FRAC_BITS_DEF;
    localparam int TDATA_W  = ((SAMPLE_W + SECIDX_BITS + SLOT_BITS + COEF_W + 7) / 8) * 8;
    localparam int RDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

    // Action code 3 has no name in the package. The block must drop it silently.
    localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
    // Slots 6 and 7 fit in the slot field but hold no coefficient.
    localparam logic [SLOT_BITS-1:0] SLOT_UNUSED_LO = 3'd6;
    localparam logic [SLOT_BITS-1:0] SLOT_UNUSED_HI = 3'd7;
    localparam logic [SECIDX_BITS-1:0] LAST_SECTION = SECIDX_BITS'(MAX_SECTIONS_DEF - 1);
    localparam logic [CFG_BITS-1:0] CFG_TOP = '1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam int UNITY     = 1 << COEF_FRAC_BITS_DEF;
    localparam int COEF_TOP  = (1 << (COEF_W - 1)) - 1;
    localparam int COEF_BOT  = -COEF_TOP - 1;

    // The settle time covers a filter word through every section. The margin also covers a
    // trailing coefficient load that is still in progress.
    localparam int SETTLE_CYCLES  = 12 * MAX_SECTIONS_DEF + 16;
    localparam int LONG_HOLD      = 3000;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_WORDS    = 40;
    localparam int PRESSURE_PHASE = 2;
    localparam int LIMIT_CYCLES   = 1000000;

    typedef struct {
        logic [ACTION_BITS-1:0]       action;
        logic signed [SAMPLE_W-1:0]   sample;
        logic [SECIDX_BITS-1:0]       section;
        logic [SLOT_BITS-1:0]         slot;
        logic signed [COEF_W-1:0]     coef;
    } t_in_word;

    typedef struct {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       saturated;
    } t_out_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata = '0;
    logic [ACTION_BITS-1:0] s_axis_tuser = ACT_FILTER;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [RDATA_W-1:0]     m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_BITS-1:0]    i_cfg_wdata = '0;

    // Words waiting to be sent, and filtered values the block still owes.
    t_in_word  word_backlog[$];
    t_out_word filtered_due[$];

    // Local copy of the cascade state: coefficient table, both delay lines and
    // the section-count register as last written.
    logic signed [COEF_W-1:0] coef_bank[MAX_SECTIONS_DEF][COEFS_PER_SECTION];
    longint                   w_one[MAX_SECTIONS_DEF];
    longint                   w_two[MAX_SECTIONS_DEF];
    logic [CFG_BITS-1:0]      section_setting = 4'd1;

    // Idle control shared between the stimulus process and the two bus processes.
    bit        send_idle_on = 1'b1;
    bit        take_idle_on = 1'b1;
    int        long_hold_asks = 0;
    int        long_hold_served = 0;
    int        send_pause = 0;
    int        take_pause = 0;
    int        hold_left = 0;
    int        mismatches = 0;
    int        cycle_count = 0;
    t_out_word due_word;

    biquad_cascade_iir_filter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The register value is clamped to the range 1 to MAX_SECTIONS_DEF.
    function automatic int active_sections(input logic [CFG_BITS-1:0] setting);
        if (setting == 0) return 1;
        if (setting > MAX_SECTIONS_DEF) return MAX_SECTIONS_DEF;
        return int'(setting);
    endfunction

    // Q4.14 product. The arithmetic shift rounds toward minus infinity.
    function automatic longint q14_product(input logic signed [COEF_W-1:0] c,
                                           input longint v);
        return (longint'(c) * v) >>> COEF_FRAC_BITS_DEF;
    endfunction

    function automatic longint clamp_signed(input longint v, input int bits, inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Applies one accepted word to the local state. For a sample, it queues the
    // output of the last active section.
    function automatic void filter_word(input t_in_word w);
        longint    x;
        longint    d1;
        longint    d2;
        longint    wn;
        bit        state_clip;
        bit        out_clip;
        t_out_word r;
        if (w.action == ACT_LOAD) begin
            if (w.slot < COEFS_PER_SECTION)
                coef_bank[w.section][w.slot] = w.coef;
        end else if (w.action == ACT_FILTER || w.action == ACT_CLEAR) begin
            if (w.action == ACT_CLEAR) begin
                foreach (w_one[s]) begin
                    w_one[s] = 0;
                    w_two[s] = 0;
                end
            end
            x = longint'(w.sample);
            state_clip = 1'b0;
            for (int s = 0; s < active_sections(section_setting); s++) begin
                d1 = w_one[s];
                d2 = w_two[s];
                wn = q14_product(coef_bank[s][SLOT_A0], x)
                   - q14_product(coef_bank[s][SLOT_A1], d1)
                   - q14_product(coef_bank[s][SLOT_A2], d2);
                wn = clamp_signed(wn, STATE_BITS, state_clip);
                x  = q14_product(coef_bank[s][SLOT_B0], wn)
                   + q14_product(coef_bank[s][SLOT_B1], d1)
                   + q14_product(coef_bank[s][SLOT_B2], d2);
                x  = clamp_signed(x, STATE_BITS, state_clip);
                w_two[s] = d1;
                w_one[s] = wn;
            end
            out_clip = 1'b0;
            x = clamp_signed(x, SAMPLE_W, out_clip);
            r.filtered  = SAMPLE_W'(x);
            r.saturated = out_clip;
            filtered_due.push_back(r);
        end
    endfunction

    // Most gaps are short. Now and then one is long.
    function automatic int pick_pause(input bit enabled);
        int roll;
        roll = $urandom_range(99);
        if (!enabled || roll < 60) return 0;
        if (roll < 88) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(10, 4);
        return $urandom_range(80, 20);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return SAMPLE_W'($urandom);
        if (roll < 85) return SAMPLE_W'(int'($urandom_range(1024)) - 512);
        case ($urandom_range(3))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Every field gets random content. The caller then sets the fields that matter.
    function automatic t_in_word random_word(input logic [ACTION_BITS-1:0] act);
        t_in_word w;
        w.action  = act;
        w.sample  = SAMPLE_W'($urandom);
        w.section = SECIDX_BITS'($urandom);
        w.slot    = SLOT_BITS'($urandom);
        w.coef    = COEF_W'($urandom);
        return w;
    endfunction

    task automatic push_sample(input logic [ACTION_BITS-1:0] act,
                               input logic signed [SAMPLE_W-1:0] value);
        t_in_word w;
        w = random_word(act);
        w.sample = value;
        word_backlog.push_back(w);
    endtask

    task automatic push_load(input logic [SECIDX_BITS-1:0] sec,
                             input logic [SLOT_BITS-1:0] slot, input int value);
        t_in_word w;
        w = random_word(ACT_LOAD);
        w.section = sec;
        w.slot    = slot;
        w.coef    = COEF_W'(value);
        word_backlog.push_back(w);
    endtask

    // Loads a stable section: |a2| <= 0.9 and |a1| < 1 + a2, gains within +/-1,
    // and a0 near unity. The output then stays mostly in range.
    task automatic load_stable_section(input logic [SECIDX_BITS-1:0] sec);
        int a2;
        int lim;
        a2  = int'($urandom_range(2 * (UNITY * 9 / 10))) - UNITY * 9 / 10;
        lim = ((UNITY + a2) * 15) / 16;
        push_load(sec, SLOT_B0, int'($urandom_range(2 * UNITY)) - UNITY);
        push_load(sec, SLOT_B1, int'($urandom_range(2 * UNITY)) - UNITY);
        push_load(sec, SLOT_B2, int'($urandom_range(2 * UNITY)) - UNITY);
        push_load(sec, SLOT_A0, ($urandom_range(3) == 0) ?
                  int'($urandom_range(3 * UNITY / 2, UNITY / 2)) : UNITY);
        push_load(sec, SLOT_A1, int'($urandom_range(2 * lim)) - lim);
        push_load(sec, SLOT_A2, a2);
    endtask

    // The register is written only while nothing is in flight. The local copy
    // takes the new value as the write enable is driven.
    task automatic set_sections(input logic [CFG_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        section_setting = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        while (word_backlog.size() != 0 || filtered_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Sender. The word at the head of the backlog stays on the bus until it is
    // taken. The bus model sees it at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_pause = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                filter_word(word_backlog.pop_front());
                send_pause = pick_pause(send_idle_on);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_pause > 0) begin
                    send_pause--;
                    s_axis_tvalid <= 1'b0;
                end else if (word_backlog.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= TDATA_W'({word_backlog[0].coef, word_backlog[0].slot,
                                               word_backlog[0].section,
                                               word_backlog[0].sample});
                    s_axis_tuser  <= word_backlog[0].action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker. A requested long hold counts down here. Other stalls
    // are drawn at random whenever no hold or pause is counting down.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (filtered_due.size() == 0) begin
                    $error("result word with nothing pending: filtered %0d, saturated %0b",
                           $signed(m_axis_tdata[SAMPLE_W-1:0]), m_axis_tuser);
                    mismatches++;
                end else begin
                    due_word = filtered_due.pop_front();
                    if (m_axis_tdata[SAMPLE_W-1:0] !== due_word.filtered) begin
                        $error("filtered: expected %0d, actual %0d", due_word.filtered,
                               $signed(m_axis_tdata[SAMPLE_W-1:0]));
                        mismatches++;
                    end
                    if (m_axis_tuser !== due_word.saturated) begin
                        $error("saturated: expected %0b, actual %0b", due_word.saturated,
                               m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            if (long_hold_served < long_hold_asks) begin
                hold_left = LONG_HOLD;
                long_hold_served++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (take_pause > 0) begin
                take_pause--;
                m_axis_tready <= 1'b0;
            end else begin
                take_pause = pick_pause(take_idle_on);
                m_axis_tready <= (take_pause == 0);
            end
        end
    end

    // Watchdog. A stalled handshake must not hang the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [CFG_BITS-1:0] setting;
        int                  roll;
        foreach (coef_bank[s, c])
            coef_bank[s][c] = '0;
        foreach (w_one[s]) begin
            w_one[s] = 0;
            w_two[s] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with one section in use as after reset. An all-zero
        // table must give zero at both sample extremes.
        push_sample(ACT_FILTER, SAMPLE_MAX);
        push_sample(ACT_FILTER, SAMPLE_MIN);
        // Unity pass-through.
        push_load(3'd0, SLOT_A0, UNITY);
        push_load(3'd0, SLOT_B0, UNITY);
        push_sample(ACT_FILTER, SAMPLE_MAX);
        push_sample(ACT_FILTER, SAMPLE_MIN);
        push_sample(ACT_FILTER, '1);
        // Extreme gains drive the output into both clip limits.
        push_load(3'd0, SLOT_B0, COEF_TOP);
        push_sample(ACT_FILTER, SAMPLE_MAX);
        push_load(3'd0, SLOT_B0, COEF_BOT);
        push_sample(ACT_FILTER, SAMPLE_MAX);
        // Loads to the two spare slots and the unused action must leave no trace.
        push_load(3'd0, SLOT_UNUSED_LO, COEF_TOP);
        push_load(3'd0, SLOT_UNUSED_HI, COEF_BOT);
        word_backlog.push_back(random_word(ACT_UNUSED));
        // Feedback terms, so that the impulse response rings.
        push_load(3'd0, SLOT_B0, UNITY);
        push_load(3'd0, SLOT_A1, -16000);
        push_load(3'd0, SLOT_A2, 8000);
        push_sample(ACT_FILTER, 16'sd20000);
        push_sample(ACT_FILTER, '0);
        push_sample(ACT_FILTER, '0);
        // A clear request zeroes the delay lines before its own sample runs.
        push_sample(ACT_CLEAR, '0);
        push_sample(ACT_FILTER, 16'sd1000);
        // A section that is not in use must not touch the output.
        push_load(LAST_SECTION, SLOT_B2, -1);
        push_sample(ACT_FILTER, 16'sd1000);

        // Random phases. The first settings are the edge cases of the register.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:              setting = '0;
                1:              setting = CFG_TOP;
                PRESSURE_PHASE: setting = CFG_BITS'(MAX_SECTIONS_DEF);
                3:              setting = 4'd1;
                default:        setting = CFG_BITS'($urandom_range(CFG_TOP));
            endcase
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            set_sections(setting);
            send_idle_on = (phase != PRESSURE_PHASE) && ($urandom_range(3) != 0);
            take_idle_on = ($urandom_range(3) != 0);
            if (phase == PRESSURE_PHASE)
                long_hold_asks++;
            for (int s = 0; s < active_sections(setting); s++)
                load_stable_section(SECIDX_BITS'(s));
            for (int k = 0; k < PHASE_WORDS; k++) begin
                roll = $urandom_range(99);
                if (roll < 76)
                    push_sample(ACT_FILTER, pick_sample());
                else if (roll < 82)
                    push_sample(ACT_CLEAR, pick_sample());
                else if (roll < 90)
                    load_stable_section(SECIDX_BITS'($urandom));
                else if (roll < 97)
                    push_load(SECIDX_BITS'($urandom), SLOT_BITS'($urandom),
                              int'(COEF_W'($urandom)) - ((roll & 1) << (COEF_W - 1)));
                else
                    word_backlog.push_back(random_word(ACT_UNUSED));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && filtered_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
